// ----- hw/rtl/tdss_pkg.sv -----
// Package for the triangle depth segment sorter.
// Holds the buffer capacity, entry type and controller command/status structs.
// No dependencies.
package tdss_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned SumW = 34;

  typedef struct packed {
    logic        is_triangle;
    logic [15:0] handle;
    logic [31:0] depth_a;
    logic [31:0] depth_b;
    logic [31:0] depth_c;
  } entry_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StSort = 4'b0010,
    StEmit = 4'b0100,
    StWait = 4'b1000
  } state_e;

  typedef struct packed {
    logic store;
    logic drop;
    logic start_sort;
    logic sort_step;
    logic emit_load;
    logic emit_clear;
  } cmd_t;

  typedef struct packed {
    logic sort_done;
    logic emit_last;
    logic empty;
  } status_t;

  function automatic logic signed [SumW-1:0] depth_sum(entry_t e);
    depth_sum = SumW'($signed(e.depth_a)) + SumW'($signed(e.depth_b))
              + SumW'($signed(e.depth_c));
  endfunction

endpackage

// ----- hw/rtl/triangle_depth_segment_sorter_core.sv -----
// Triangle depth segment sorter: buffers up to 64 draw commands, one per
// transaction, and on a batch-end command sorts each run of consecutive
// triangles by descending depth sum (stable), then emits every stored command.
// Input is accepted only while idle. After the batch-end transaction of a batch,
// the sort runs odd-even passes over the cell row, then the stored entries are
// emitted in order, one per output handshake, and output stalls hold emission;
// no input is accepted until the last result is taken.
// Depends on tdss_pkg, tdss_ctrl and tdss_datapath.
module triangle_depth_segment_sorter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        is_triangle_i,
  input  logic [31:0] depth_a_i,
  input  logic [31:0] depth_b_i,
  input  logic [31:0] depth_c_i,
  input  logic [15:0] handle_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_handle_o,
  output logic        out_is_triangle_o,
  output logic [31:0] out_depth_a_o,
  output logic [31:0] out_depth_b_o,
  output logic [31:0] out_depth_c_o,
  output logic        dropped_any_o,
  output logic        final_item_o
);
  import tdss_pkg::*;

  cmd_t    cmd;
  status_t sts;
  entry_t  in_entry, out_entry;
  logic    full;

  assign in_entry = '{is_triangle: is_triangle_i, handle: handle_i,
                      depth_a: depth_a_i, depth_b: depth_b_i, depth_c: depth_c_i};

  tdss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .batch_end_i,
    .full_i(full), .out_valid_o, .out_ready_i, .cmd_o(cmd), .sts_i(sts)
  );

  tdss_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_entry_i(in_entry),
    .out_entry_o(out_entry), .out_dropped_o(dropped_any_o), .out_final_o(final_item_o),
    .full_o(full)
  );

  assign out_handle_o      = out_entry.handle;
  assign out_is_triangle_o = out_entry.is_triangle;
  assign out_depth_a_o     = out_entry.depth_a;
  assign out_depth_b_o     = out_entry.depth_b;
  assign out_depth_c_o     = out_entry.depth_c;

endmodule

// ----- hw/rtl/tdss_datapath.sv -----
// Datapath: entry buffer, odd-even transposition sort cell row and output register.
// Depends on tdss_pkg.
module tdss_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdss_pkg::cmd_t    cmd_i,
  output tdss_pkg::status_t sts_o,
  input  tdss_pkg::entry_t  in_entry_i,
  output tdss_pkg::entry_t  out_entry_o,
  output logic             out_dropped_o,
  output logic             out_final_o,
  output logic             full_o
);
  import tdss_pkg::*;

  // The buffer is a row of cells; each new triangle is inserted into its run
  // by the sorting pass, one compare-and-swap over all odd or even pairs a cycle.
  entry_t            cell_q [Capacity];
  entry_t            cell_d [Capacity];
  logic [CntW-1:0]   fill_q;
  logic              ovf_q;
  logic [CntW-1:0]   emit_q;
  logic [CntW-1:0]   pass_q;
  logic              phase_q;
  logic [SumW-1:0]   sum_q [Capacity];
  logic [SumW-1:0]   sum_d [Capacity];

  // Odd-even transposition sort restricted to adjacent triangles is stable and
  // equals the stable insertion sort within each barrier-delimited run.
  always_comb begin
    for (int k = 0; k < Capacity; k++) begin
      cell_d[k] = cell_q[k];
      sum_d[k]  = sum_q[k];
    end
    for (int k = 0; k + 1 < Capacity; k++) begin
      if ((k[0] == phase_q) && (CntW'(k + 1) < fill_q) && cell_q[k].is_triangle &&
          cell_q[k + 1].is_triangle &&
          ($signed(sum_q[k]) < $signed(sum_q[k + 1]))) begin
        cell_d[k]     = cell_q[k + 1];
        cell_d[k + 1] = cell_q[k];
        sum_d[k]      = sum_q[k + 1];
        sum_d[k + 1]  = sum_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      cell_q[fill_q[IdxW-1:0]] <= in_entry_i;
      sum_q[fill_q[IdxW-1:0]]  <= depth_sum(in_entry_i);
    end else if (cmd_i.sort_step) begin
      for (int k = 0; k < Capacity; k++) begin
        cell_q[k] <= cell_d[k];
        sum_q[k]  <= sum_d[k];
      end
    end
    if (cmd_i.emit_load) begin
      out_entry_o <= cell_q[emit_q[IdxW-1:0]];
      out_dropped_o <= ovf_q;
      out_final_o <= (emit_q + CntW'(1) == fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      emit_q  <= '0;
      pass_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cmd_i.store) fill_q <= fill_q + CntW'(1);
      if (cmd_i.drop) ovf_q <= 1'b1;
      if (cmd_i.start_sort) begin
        pass_q  <= '0;
        phase_q <= 1'b0;
        emit_q  <= '0;
      end else if (cmd_i.sort_step) begin
        pass_q  <= pass_q + CntW'(1);
        phase_q <= ~phase_q;
      end
      if (cmd_i.emit_load) emit_q <= emit_q + CntW'(1);
      if (cmd_i.emit_clear) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  assign sts_o.sort_done = (pass_q >= fill_q);
  assign sts_o.emit_last = (emit_q + CntW'(1) == fill_q);
  assign sts_o.empty     = (fill_q == '0);
  assign full_o          = (fill_q == CntW'(Capacity));

endmodule

// ----- hw/rtl/tdss_ctrl.sv -----
// Controller: accepts commands, runs the sort passes and sequences emission.
// Depends on tdss_pkg.
module tdss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              batch_end_i,
  input  logic              full_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tdss_pkg::cmd_t    cmd_o,
  input  tdss_pkg::status_t sts_i
);
  import tdss_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   acc;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.store = !full_i;
          cmd_o.drop  = full_i;
          if (batch_end_i) begin
            cmd_o.start_sort = 1'b1;
            state_d = StSort;
          end
        end
      end
      StSort: begin
        if (sts_i.sort_done) begin
          state_d = sts_i.empty ? StIdle : StEmit;
          cmd_o.emit_clear = sts_i.empty;
        end else begin
          cmd_o.sort_step = 1'b1;
        end
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.emit_load = 1'b1;
          ov_d = 1'b1;
          if (sts_i.emit_last) state_d = StWait;
        end
      end
      StWait: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          cmd_o.emit_clear = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (state_q == StEmit && ov_q && out_ready_i && !cmd_o.emit_load) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ----- sim/triangle_depth_segment_sorter_core_tb.sv -----
// Testbench for triangle_depth_segment_sorter_core: drives draw-command batches and checks
// every emitted command against a stable per-run depth-sum sort predictor.
// Depends on tdss_pkg and the core RTL.
`timescale 1ns / 100ps

module triangle_depth_segment_sorter_core_tb;
  import tdss_pkg::*;

  typedef struct {
    logic        tri_f;
    logic [31:0] da;
    logic [31:0] db;
    logic [31:0] dc;
    logic [15:0] hnd;
    logic        last;
  } cmd_s;

  typedef struct {
    logic [15:0] hnd;
    logic        tri_f;
    logic [31:0] da;
    logic [31:0] db;
    logic [31:0] dc;
    logic        dropped;
    logic        fin;
  } drawn_s;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic is_triangle_i = 1'b0;
  logic [31:0] depth_a_i = '0;
  logic [31:0] depth_b_i = '0;
  logic [31:0] depth_c_i = '0;
  logic [15:0] handle_i = '0;
  logic batch_end_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] out_handle_o;
  logic out_is_triangle_o;
  logic [31:0] out_depth_a_o, out_depth_b_o, out_depth_c_o;
  logic dropped_any_o, final_item_o;

  triangle_depth_segment_sorter_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("triangle_depth_segment_sorter_core_tb failed");
    $finish;
  end

  entry_t batch_buf[$];
  logic   batch_drop;
  drawn_s sorted_q[$];
  int     mismatches;
  int     send_idle_pct, recv_idle_pct;
  int     hold_cycles;

  function automatic logic signed [35:0] tri_sum(entry_t e);
    return 36'($signed(e.depth_a)) + 36'($signed(e.depth_b)) + 36'($signed(e.depth_c));
  endfunction

  function automatic void sort_batch_runs(input cmd_s c);
    entry_t e, k;
    int j;
    drawn_s d;
    if (batch_buf.size() < Capacity) begin
      e.is_triangle = c.tri_f; e.handle = c.hnd;
      e.depth_a = c.da; e.depth_b = c.db; e.depth_c = c.dc;
      batch_buf.push_back(e);
    end else begin
      batch_drop = 1'b1;
    end
    if (!c.last) return;
    for (int i = 1; i < batch_buf.size(); i++) begin
      if (!batch_buf[i].is_triangle) continue;
      k = batch_buf[i];
      j = i;
      while (j > 0 && batch_buf[j-1].is_triangle && tri_sum(batch_buf[j-1]) < tri_sum(k)) begin
        batch_buf[j] = batch_buf[j-1];
        j--;
      end
      batch_buf[j] = k;
    end
    foreach (batch_buf[i]) begin
      d.hnd = batch_buf[i].handle; d.tri_f = batch_buf[i].is_triangle;
      d.da = batch_buf[i].depth_a; d.db = batch_buf[i].depth_b; d.dc = batch_buf[i].depth_c;
      d.dropped = batch_drop; d.fin = (i == batch_buf.size() - 1);
      sorted_q.push_back(d);
    end
    batch_buf.delete();
    batch_drop = 1'b0;
  endfunction

  task automatic send_cmd(input cmd_s c);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    is_triangle_i <= c.tri_f;
    depth_a_i <= c.da;
    depth_b_i <= c.db;
    depth_c_i <= c.dc;
    handle_i <= c.hnd;
    batch_end_i <= c.last;
    do @(posedge clk_i); while (!in_ready_o);
    sort_batch_runs(c);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    drawn_s x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction, handle %h", out_handle_o);
      end else begin
        x = sorted_q.pop_front();
        if (x.hnd !== out_handle_o || x.tri_f !== out_is_triangle_o ||
            x.da !== out_depth_a_o || x.db !== out_depth_b_o || x.dc !== out_depth_c_o ||
            x.dropped !== dropped_any_o || x.fin !== final_item_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp h=%h t=%b %h %h %h d=%b f=%b got h=%h t=%b %h %h %h d=%b f=%b",
                     x.hnd, x.tri_f, x.da, x.db, x.dc, x.dropped, x.fin, out_handle_o,
                     out_is_triangle_o, out_depth_a_o, out_depth_b_o, out_depth_c_o,
                     dropped_any_o, final_item_o);
        end
      end
    end
  end

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      3: return 32'($signed($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_s rand_cmd(input logic last);
    cmd_s c;
    c.tri_f = ($urandom_range(99) < 80);
    c.da = rand_depth(); c.db = rand_depth(); c.dc = rand_depth();
    c.hnd = 16'($urandom);
    c.last = last;
    return c;
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_cmd(rand_cmd(i == len - 1));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
  endtask

  cmd_s dir_tab[] = '{
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0000, 1'b1},
    '{1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b1},
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0001, 1'b0},
    '{1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0002, 1'b0},
    '{1'b1, 32'h0000_0005, 32'h0, 32'h0, 16'h0003, 1'b0},
    '{1'b1, 32'h0, 32'h0000_0005, 32'h0, 16'h0004, 1'b0},
    '{1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0005, 1'b0},
    '{1'b1, 32'hffff_ffff, 32'h0, 32'h0, 16'h0006, 1'b0},
    '{1'b1, 32'h0000_0010, 32'h0, 32'h0, 16'h0007, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 16'h0008, 1'b0},
    '{1'b0, 32'h1, 32'h2, 32'h3, 16'h0009, 1'b0},
    '{1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 16'h000a, 1'b0},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h000b, 1'b0},
    '{1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 16'h000c, 1'b1}
  };

  initial begin
    int bl;
    mismatches = 0;
    batch_drop = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_cmd(dir_tab[i]);
    drain();

    // Fill past capacity so the overflow flag and a dropped batch-end are seen.
    for (int i = 0; i < Capacity + 2; i++) send_cmd(rand_cmd(i == Capacity + 1));
    drain();
    for (int i = 0; i < Capacity + 1; i++) send_cmd(rand_cmd(1'b0));
    send_cmd(rand_cmd(1'b1));
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 14 : 0;
      bl = 0;
      while (bl < 40) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(Capacity + 3, 20) : $urandom_range(8, 1);
        send_batch(len);
        bl += len;
      end
      if (ph == 1) begin
        hold_cycles = 300;
        send_batch(20);
        send_batch(10);
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("triangle_depth_segment_sorter_core_tb passed");
    end else begin
      $display("triangle_depth_segment_sorter_core_tb failed");
    end
    $finish;
  end

endmodule
